@@ src/lcra_pkg.sv @@
`default_nettype none

package lcra_pkg;

   localparam int CFG_W   = 7;
   localparam int AREA_W  = 13;
   localparam int NBR_CNT = 8;
   localparam logic [AREA_W-1:0] AREA_MAX = 13'd8191;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PREP,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_POP,
      ST_POPW,
      ST_NB,
      ST_DONE
   } state_type;

   // direction of one of the eight neighbors
   typedef struct packed {
      logic up;
      logic down;
      logic left;
      logic right;
   } nbr_dir_type;

   function automatic nbr_dir_type nbr_dir(input logic [2:0] k);
      nbr_dir_type d;
      d = '0;
      unique case (k)
         3'd0: d = '{up: 1'b1, down: 1'b0, left: 1'b1, right: 1'b0};
         3'd1: d = '{up: 1'b1, down: 1'b0, left: 1'b0, right: 1'b0};
         3'd2: d = '{up: 1'b1, down: 1'b0, left: 1'b0, right: 1'b1};
         3'd3: d = '{up: 1'b0, down: 1'b0, left: 1'b1, right: 1'b0};
         3'd4: d = '{up: 1'b0, down: 1'b0, left: 1'b0, right: 1'b1};
         3'd5: d = '{up: 1'b0, down: 1'b1, left: 1'b1, right: 1'b0};
         3'd6: d = '{up: 1'b0, down: 1'b1, left: 1'b0, right: 1'b0};
         3'd7: d = '{up: 1'b0, down: 1'b1, left: 1'b0, right: 1'b1};
         default: d = '0;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

@@ src/lcra_ram.sv @@
`default_nettype none

module lcra_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ src/lcra_nbr.sv @@
`default_nettype none

// Address and column of one neighbor of the popped pixel, with bounds check.
module lcra_nbr #(
   parameter int ADDR_W = 12,
   parameter int COL_W  = 6,
   parameter int WID_W  = 7,
   parameter int CNT_W  = 13
) (
   input  wire logic [ADDR_W-1:0] pos,
   input  wire logic [COL_W-1:0]  col,
   input  wire logic [2:0]        k,
   input  wire logic [WID_W-1:0]  width,
   input  wire logic [CNT_W-1:0]  count,
   output logic                   nbr_valid,
   output logic      [ADDR_W-1:0] nbr_addr,
   output logic      [COL_W-1:0]  nbr_col
);

   localparam int QW = ADDR_W + 2;

   lcra_pkg::nbr_dir_type dir;
   logic [QW-1:0]         q;
   logic                  row_ok;
   logic                  col_ok;

   always_comb begin
      dir    = lcra_pkg::nbr_dir(k);
      row_ok = !dir.up || (QW'(pos) >= QW'(width));
      col_ok = (!dir.left || (col != '0)) &&
               (!dir.right || ((WID_W+1)'(col) + (WID_W+1)'(1) < (WID_W+1)'(width)));
      q = QW'(pos);
      if (dir.down) begin
         q = q + QW'(width);
      end
      if (dir.up) begin
         q = q - QW'(width);
      end
      if (dir.right) begin
         q = q + QW'(1);
      end
      if (dir.left) begin
         q = q - QW'(1);
      end
      nbr_valid = row_ok && col_ok && (q < QW'(count));
      nbr_addr  = q[ADDR_W-1:0];
      if (dir.left) begin
         nbr_col = col - COL_W'(1);
      end else if (dir.right) begin
         nbr_col = col + COL_W'(1);
      end else begin
         nbr_col = col;
      end
   end

endmodule

`default_nettype wire

@@ src/largest_connected_region_area.sv @@
// Largest 8-connected region of ones in a binary image.
// Input channel (req_): one pixel per beat in row-major order; req_last_pixel
// marks the final pixel. Pixels are taken one per cycle while loading.
// Result channel (rsp_): one beat per image carrying the pixel count of the
// largest region (0 if no ones, saturated at 8191).
// csr_wr_en/csr_wr_data set the row width (0 acts as 1, clamped to MAX_COLS).
// After the last pixel the image is scanned from the pixel map RAM, with a
// read state and a check state per scanned pixel; each pixel of a region
// costs a stack pop, a pop data state and eight neighbor reads pipelined
// against visited updates, plus one more pop per region to close it. The
// map and stack RAMs, one access each per cycle, set this pace. req_stall
// is high from the last pixel until the result enters its output register.
// The result sits in an output register; if rsp_stall holds it, the next
// image still loads, and only its evaluation end waits for the register.
// Reset (synchronous) empties the block and sets the row width to 64.
// The visited bits live beside each pixel and are cleared as pixels load.
`default_nettype none

module largest_connected_region_area #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_pixel,
   input  wire logic        req_last_pixel,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [12:0]      rsp_largest_area,
   input  wire logic        csr_wr_en,
   input  wire logic [6:0]  csr_wr_data
);

   localparam int CELLS = MAX_ROWS * MAX_COLS;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int WW    = $clog2(MAX_COLS + 1);
   localparam int LW    = $clog2(CELLS + 1);
   localparam int EW    = (WW > lcra_pkg::CFG_W) ? WW : lcra_pkg::CFG_W;
   localparam int XW    = (LW > lcra_pkg::AREA_W) ? LW : lcra_pkg::AREA_W;
   localparam int SW    = AW + CW;

   lcra_pkg::state_type state_ff, state_in;

   logic [lcra_pkg::CFG_W-1:0] row_width_ff;
   logic [LW-1:0]  lp_ff, lp_in;
   logic [WW-1:0]  w_ff, w_in;
   logic [LW-1:0]  n_ff, n_in;
   logic [LW-1:0]  s_ff, s_in;
   logic [CW-1:0]  sc_ff, sc_in;
   logic [LW-1:0]  sp_ff, sp_in;
   logic [AW-1:0]  p_ff, p_in;
   logic [CW-1:0]  c_ff, c_in;
   logic [3:0]     k_ff, k_in;
   logic           chk_valid_ff, chk_valid_in;
   logic [AW-1:0]  chk_addr_ff, chk_addr_in;
   logic [CW-1:0]  chk_col_ff, chk_col_in;
   logic [LW-1:0]  area_ff, area_in;
   logic [LW-1:0]  best_ff, best_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [lcra_pkg::AREA_W-1:0] rsp_area_ff, rsp_area_in;

   // pixel map: bit 1 visited, bit 0 pixel
   logic           map_we;
   logic [AW-1:0]  map_waddr;
   logic [1:0]     map_wdata;
   logic [AW-1:0]  map_raddr;
   logic [1:0]     map_rdata;

   logic           stk_we;
   logic [AW-1:0]  stk_waddr;
   logic [SW-1:0]  stk_wdata;
   logic [AW-1:0]  stk_raddr;
   logic [SW-1:0]  stk_rdata;

   logic           nbr_valid;
   logic [AW-1:0]  nbr_addr;
   logic [CW-1:0]  nbr_col;

   logic           in_beat;
   logic           out_free;
   logic           fresh;
   logic [EW-1:0]  cfg_ext;
   logic [WW-1:0]  eff_w;
   logic [LW-1:0]  limit;

   assign req_stall        = (state_ff != lcra_pkg::ST_LOAD);
   assign in_beat          = req_valid && !req_stall;
   assign out_free         = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_largest_area = rsp_area_ff;
   assign fresh            = chk_valid_ff && map_rdata[0] && !map_rdata[1];

   lcra_ram #(.WIDTH(2), .DEPTH(CELLS)) u_map (
      .clock      (clock),
      .wr_en      (map_we),
      .wr_addr    (map_waddr),
      .wr_data    (map_wdata),
      .rd_addr    (map_raddr),
      .rd_data_ff (map_rdata)
   );

   lcra_ram #(.WIDTH(SW), .DEPTH(CELLS)) u_stack (
      .clock      (clock),
      .wr_en      (stk_we),
      .wr_addr    (stk_waddr),
      .wr_data    (stk_wdata),
      .rd_addr    (stk_raddr),
      .rd_data_ff (stk_rdata)
   );

   lcra_nbr #(.ADDR_W(AW), .COL_W(CW), .WID_W(WW), .CNT_W(LW)) u_nbr (
      .pos       (p_ff),
      .col       (c_ff),
      .k         (k_ff[2:0]),
      .width     (w_ff),
      .count     (n_ff),
      .nbr_valid (nbr_valid),
      .nbr_addr  (nbr_addr),
      .nbr_col   (nbr_col)
   );

   always_comb begin
      cfg_ext = EW'(row_width_ff);
      if (cfg_ext == '0) begin
         eff_w = WW'(1);
      end else if (cfg_ext > EW'(MAX_COLS)) begin
         eff_w = WW'(MAX_COLS);
      end else begin
         eff_w = cfg_ext[WW-1:0];
      end
      limit = LW'(MAX_ROWS) * LW'(w_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lcra_pkg::ST_LOAD: begin
            if (in_beat && req_last_pixel) begin
               state_in = lcra_pkg::ST_PREP;
            end
         end
         lcra_pkg::ST_PREP: state_in = lcra_pkg::ST_SCAN_RD;
         lcra_pkg::ST_SCAN_RD: begin
            state_in = (s_ff == n_ff) ? lcra_pkg::ST_DONE : lcra_pkg::ST_SCAN_CHK;
         end
         lcra_pkg::ST_SCAN_CHK: begin
            if (map_rdata[0] && !map_rdata[1]) begin
               state_in = lcra_pkg::ST_POP;
            end else begin
               state_in = lcra_pkg::ST_SCAN_RD;
            end
         end
         lcra_pkg::ST_POP: begin
            state_in = (sp_ff == '0) ? lcra_pkg::ST_SCAN_RD : lcra_pkg::ST_POPW;
         end
         lcra_pkg::ST_POPW: state_in = lcra_pkg::ST_NB;
         lcra_pkg::ST_NB: begin
            if (k_ff == 4'(lcra_pkg::NBR_CNT)) begin
               state_in = lcra_pkg::ST_POP;
            end
         end
         lcra_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = lcra_pkg::ST_LOAD;
            end
         end
         default: state_in = lcra_pkg::ST_LOAD;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      lp_in        = lp_ff;
      w_in         = w_ff;
      n_in         = n_ff;
      s_in         = s_ff;
      sc_in        = sc_ff;
      sp_in        = sp_ff;
      p_in         = p_ff;
      c_in         = c_ff;
      k_in         = k_ff;
      chk_valid_in = 1'b0;
      chk_addr_in  = chk_addr_ff;
      chk_col_in   = chk_col_ff;
      area_in      = area_ff;
      best_in      = best_ff;
      rsp_area_in  = rsp_area_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      map_we       = 1'b0;
      map_waddr    = s_ff[AW-1:0];
      map_wdata    = 2'b11;
      map_raddr    = s_ff[AW-1:0];
      stk_we       = 1'b0;
      stk_waddr    = sp_ff[AW-1:0];
      stk_wdata    = {s_ff[AW-1:0], sc_ff};
      stk_raddr    = sp_ff[AW-1:0] - AW'(1);

      unique case (state_ff)
         lcra_pkg::ST_LOAD: begin
            map_waddr = lp_ff[AW-1:0];
            map_wdata = {1'b0, req_pixel};
            if (in_beat) begin
               if (lp_ff < LW'(CELLS)) begin
                  map_we = 1'b1;
                  lp_in  = lp_ff + LW'(1);
               end
               if (req_last_pixel) begin
                  w_in = eff_w;
               end
            end
         end
         lcra_pkg::ST_PREP: begin
            n_in    = (lp_ff < limit) ? lp_ff : limit;
            lp_in   = '0;
            s_in    = '0;
            sc_in   = '0;
            best_in = '0;
         end
         lcra_pkg::ST_SCAN_RD: begin
         end
         lcra_pkg::ST_SCAN_CHK: begin
            if (map_rdata[0] && !map_rdata[1]) begin
               // seed a new region
               map_we  = 1'b1;
               stk_we  = 1'b1;
               sp_in   = sp_ff + LW'(1);
               area_in = '0;
            end else begin
               s_in  = s_ff + LW'(1);
               sc_in = (WW'(sc_ff) + WW'(1) == w_ff) ? '0 : sc_ff + CW'(1);
            end
         end
         lcra_pkg::ST_POP: begin
            if (sp_ff == '0) begin
               if (area_ff > best_ff) begin
                  best_in = area_ff;
               end
               s_in  = s_ff + LW'(1);
               sc_in = (WW'(sc_ff) + WW'(1) == w_ff) ? '0 : sc_ff + CW'(1);
            end else begin
               sp_in = sp_ff - LW'(1);
            end
         end
         lcra_pkg::ST_POPW: begin
            p_in    = stk_rdata[SW-1:CW];
            c_in    = stk_rdata[CW-1:0];
            area_in = area_ff + LW'(1);
            k_in    = '0;
         end
         lcra_pkg::ST_NB: begin
            // issue neighbor k, settle neighbor k-1 from the read data
            map_raddr = nbr_addr;
            if (k_ff != 4'(lcra_pkg::NBR_CNT)) begin
               chk_valid_in = nbr_valid;
               chk_addr_in  = nbr_addr;
               chk_col_in   = nbr_col;
               k_in         = k_ff + 4'd1;
            end
            map_waddr = chk_addr_ff;
            stk_wdata = {chk_addr_ff, chk_col_ff};
            if (fresh) begin
               map_we = 1'b1;
               stk_we = 1'b1;
               sp_in  = sp_ff + LW'(1);
            end
         end
         lcra_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (XW'(best_ff) > XW'(lcra_pkg::AREA_MAX)) begin
                  rsp_area_in = lcra_pkg::AREA_MAX;
               end else begin
                  rsp_area_in = best_ff[lcra_pkg::AREA_W-1:0];
               end
               sp_in   = '0;
               area_in = '0;
               best_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcra_pkg::ST_LOAD;
         row_width_ff <= 7'd64;
         lp_ff        <= '0;
         n_ff         <= '0;
         sp_ff        <= '0;
         area_ff      <= '0;
         best_ff      <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) begin
            row_width_ff <= csr_wr_data;
         end
         lp_ff        <= lp_in;
         n_ff         <= n_in;
         sp_ff        <= sp_in;
         area_ff      <= area_in;
         best_ff      <= best_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff        <= w_in;
      s_ff        <= s_in;
      sc_ff       <= sc_in;
      p_ff        <= p_in;
      c_ff        <= c_in;
      k_ff        <= k_in;
      chk_addr_ff <= chk_addr_in;
      chk_col_ff  <= chk_col_in;
      rsp_area_ff <= rsp_area_in;
   end

   // each pixel is pushed once at most, so the stack never overflows
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= LW'(CELLS))
      else $error("pending stack overflow");

   a_push: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lcra_pkg::ST_NB) && fresh |=> sp_ff == $past(sp_ff) + LW'(1))
      else $error("unvisited neighbor not pushed");

   a_area_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lcra_pkg::ST_SCAN_RD || state_ff == lcra_pkg::ST_SCAN_CHK ||
       state_ff == lcra_pkg::ST_POP || state_ff == lcra_pkg::ST_POPW ||
       state_ff == lcra_pkg::ST_NB) |-> (area_ff <= n_ff) && (best_ff <= n_ff))
      else $error("region area exceeds image size");

   a_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lcra_pkg::ST_DONE) && out_free |=>
         rsp_valid_ff && (state_ff == lcra_pkg::ST_LOAD))
      else $error("result not issued at end of evaluation");

endmodule

`default_nettype wire
